FILE: hw/rtl/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants of the hop receiver tracker.
// ----------------------------------------------------------------------------
package hrt_pkg;

    // Event codes carried in the op field
    typedef enum logic [1:0] {
        OP_PACKET  = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_TICK    = 2'd2,
        OP_LOAD    = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SYNC_CHAN_A = 2'd0,
        REG_SYNC_CHAN_B = 2'd1,
        REG_SYNC_CHAN_C = 2'd2
    } reg_idx_t;

    localparam int          CHAN_W         = 7;
    localparam int          CNT_W          = 16;
    localparam int          HOP_IDX_W      = 16;
    localparam int          SLOT_W         = 6;
    localparam logic [2:0]  MODE_HOPPING   = 3'd0;
    localparam logic [2:0]  MODE_NEED_SYNC = 3'd6;
    localparam logic [1:0]  SYNC_LAST      = 2'd2;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;

    // Result of one event, minus the hop table channel read from the table RAM
    typedef struct packed {
        logic              chan_valid;
        logic              use_table;
        logic [CHAN_W-1:0] alt_chan;
        logic [2:0]        link_state;
        logic              restart_timer;
        logic              hop_error;
        logic              stats_valid;
        logic [CNT_W-1:0]  good_total;
        logic [CNT_W-1:0]  good_in_sync;
        logic [CNT_W-1:0]  lost_waits;
    } hrt_result_t;

    // Saturating increment of a 16-bit counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

FILE: hw/rtl/hrt_hop_mem.sv
// ----------------------------------------------------------------------------
// hrt_hop_mem
// Hop table: synchronous RAM, separate write and read ports, one write and one
// read per cycle, read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
module hrt_hop_mem
    import hrt_pkg::*;
#(
    parameter  int HOP_LEN = 64,
    localparam int IDX_W   = $clog2(HOP_LEN)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [CHAN_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [CHAN_W-1:0] rd_data
);

    logic [CHAN_W-1:0] mem [HOP_LEN];
    logic [CHAN_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/hrt_link_ctrl.sv
// ----------------------------------------------------------------------------
// hrt_link_ctrl
// Link state machine and counters: updates the tracker state for each
// accepted word, issues the hop table access and forms the event result.
// ----------------------------------------------------------------------------
module hrt_link_ctrl
    import hrt_pkg::*;
#(
    parameter  int HOP_LEN = 64,
    localparam int IDX_W   = $clog2(HOP_LEN)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [CHAN_W-1:0]    cfg_data,
    // accepted event
    input  logic                 accept,
    input  logic [1:0]           op,
    input  logic [HOP_IDX_W-1:0] next_hop,
    input  logic [SLOT_W-1:0]    table_slot,
    input  logic [CHAN_W-1:0]    table_chan,
    // hop table access
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_addr,
    output logic [CHAN_W-1:0]    mem_wr_data,
    output logic                 mem_rd_en,
    output logic [IDX_W-1:0]     mem_rd_addr,
    // event result
    output hrt_result_t          result
);

    logic [IDX_W-1:0]  hop_pos_reg,        hop_pos_next;
    logic [1:0]        sync_pos_reg,       sync_pos_next;
    logic [2:0]        link_mode_reg,      link_mode_next;
    logic [CNT_W-1:0]  good_count_reg,     good_count_next;
    logic [CNT_W-1:0]  good_sync_count_reg, good_sync_count_next;
    logic [CNT_W-1:0]  lost_count_reg,     lost_count_next;
    logic [CHAN_W-1:0] sync_chan_reg [3];

    logic hop_in_range;
    logic slot_in_range;
    logic mem_rd_req;
    logic mem_wr_req;

    assign hop_in_range  = {1'b0, next_hop} < 17'(HOP_LEN);
    assign slot_in_range = 9'(table_slot) < 9'(HOP_LEN);

    // Next state and result for the event at the input
    always_comb begin
        hop_pos_next         = hop_pos_reg;
        sync_pos_next        = sync_pos_reg;
        link_mode_next       = link_mode_reg;
        good_count_next      = good_count_reg;
        good_sync_count_next = good_sync_count_reg;
        lost_count_next      = lost_count_reg;
        mem_rd_req           = 1'b0;
        mem_wr_req           = 1'b0;
        result               = '0;

        case (op_t'(op))
            OP_PACKET: begin
                if (hop_in_range) begin
                    good_count_next = sat_inc(good_count_reg);
                    if (link_mode_reg == MODE_NEED_SYNC) begin
                        good_sync_count_next = sat_inc(good_sync_count_reg);
                    end
                    link_mode_next       = MODE_HOPPING;
                    hop_pos_next         = IDX_W'(next_hop);
                    mem_rd_req           = 1'b1;
                    result.chan_valid    = 1'b1;
                    result.use_table     = 1'b1;
                    result.restart_timer = 1'b1;
                end else begin
                    result.hop_error = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                if (link_mode_reg < MODE_NEED_SYNC) begin
                    // lost slot: follow the hop sequence blind
                    link_mode_next = link_mode_reg + 3'd1;
                    if (hop_pos_reg == IDX_W'(HOP_LEN - 1)) begin
                        hop_pos_next = '0;
                    end else begin
                        hop_pos_next = hop_pos_reg + IDX_W'(1);
                    end
                    mem_rd_req        = 1'b1;
                    result.chan_valid = 1'b1;
                    result.use_table  = 1'b1;
                end else begin
                    // waiting for sync: step the sync ring
                    link_mode_next  = MODE_NEED_SYNC;
                    lost_count_next = sat_inc(lost_count_reg);
                    if (sync_pos_reg < SYNC_LAST) begin
                        sync_pos_next = sync_pos_reg + 2'd1;
                    end else begin
                        sync_pos_next = '0;
                    end
                    result.chan_valid = 1'b1;
                    result.alt_chan   = sync_chan_reg[sync_pos_next];
                end
            end
            OP_TICK: begin
                result.stats_valid   = 1'b1;
                result.good_total    = good_count_reg;
                result.good_in_sync  = good_sync_count_reg;
                result.lost_waits    = lost_count_reg;
                good_count_next      = '0;
                good_sync_count_next = '0;
                lost_count_next      = '0;
            end
            OP_LOAD: begin
                mem_wr_req = slot_in_range;
            end
            default: begin
            end
        endcase

        result.link_state = link_mode_next;
    end

    // Hop table access happens on the accept edge
    assign mem_rd_en   = accept & mem_rd_req;
    assign mem_rd_addr = hop_pos_next;
    assign mem_wr_en   = accept & mem_wr_req;
    assign mem_wr_addr = IDX_W'(table_slot);
    assign mem_wr_data = table_chan;

    // Tracker state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_pos_reg         <= '0;
            sync_pos_reg        <= '0;
            link_mode_reg       <= MODE_NEED_SYNC;
            good_count_reg      <= '0;
            good_sync_count_reg <= '0;
            lost_count_reg      <= '0;
        end else if (accept) begin
            hop_pos_reg         <= hop_pos_next;
            sync_pos_reg        <= sync_pos_next;
            link_mode_reg       <= link_mode_next;
            good_count_reg      <= good_count_next;
            good_sync_count_reg <= good_sync_count_next;
            lost_count_reg      <= lost_count_next;
        end
    end

    // Sync ring channel registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_chan_reg[0] <= '0;
            sync_chan_reg[1] <= '0;
            sync_chan_reg[2] <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_SYNC_CHAN_A: sync_chan_reg[0] <= cfg_data;
                REG_SYNC_CHAN_B: sync_chan_reg[1] <= cfg_data;
                REG_SYNC_CHAN_C: sync_chan_reg[2] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/hop_receiver_tracker_unit.sv
// ----------------------------------------------------------------------------
// hop_receiver_tracker_unit
// Receive-side frequency-hop tracker with hop table, link state and counters.
// ----------------------------------------------------------------------------
// Takes one event word per cycle while the output side is ready and returns
// exactly one result word for it, via the read stage and the output register.
// The state is updated at the accept edge, where the hop table is also read
// (packet, lost slot) or written (table load); the registered table data is
// merged into the result in the read stage, and an output register lets the
// next word enter while a result waits. The table port serves at most one
// access per word, which sets the sustained rate of one word per cycle. The
// table has no reset: entries must be loaded before a packet or timeout
// selects them. Configuration writes are taken in any cycle outside reset and
// set the three sync channels. Neither channel accepts a word while in reset.
// ----------------------------------------------------------------------------
module hop_receiver_tracker_unit
    import hrt_pkg::*;
#(
    parameter  int HOP_LEN = 64,
    localparam int IDX_W   = $clog2(HOP_LEN)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_addr,
    input  logic [CHAN_W-1:0]    cfg_data,
    // event input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic [HOP_IDX_W-1:0] s_next_hop,
    input  logic [SLOT_W-1:0]    s_table_slot,
    input  logic [CHAN_W-1:0]    s_table_chan,
    // result output channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_chan_valid,
    output logic [CHAN_W-1:0]    m_radio_chan,
    output logic [2:0]           m_link_state,
    output logic                 m_restart_timer,
    output logic                 m_hop_error,
    output logic                 m_stats_valid,
    output logic [CNT_W-1:0]     m_good_total,
    output logic [CNT_W-1:0]     m_good_in_sync,
    output logic [CNT_W-1:0]     m_lost_waits
);

    logic              accept;
    logic              out_load;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [CHAN_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [CHAN_W-1:0] mem_rd_data;
    hrt_result_t       ctrl_result;

    logic              rd_valid_reg,  rd_valid_next;
    hrt_result_t       rd_result_reg;
    logic              out_valid_reg, out_valid_next;
    hrt_result_t       out_result_reg;
    logic [CHAN_W-1:0] out_chan_reg;

    // Handshake: output register frees the read stage, read stage frees the input
    assign out_load  = rd_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready   = aresetn & (~rd_valid_reg | out_load);
    assign accept    = s_valid & s_ready;
    assign cfg_ready = aresetn;

    hrt_link_ctrl #(
        .HOP_LEN (HOP_LEN)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .op          (s_op),
        .next_hop    (s_next_hop),
        .table_slot  (s_table_slot),
        .table_chan  (s_table_chan),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .result      (ctrl_result)
    );

    hrt_hop_mem #(
        .HOP_LEN (HOP_LEN)
    ) u_hop_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Stage valid flags
    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (accept) begin
            rd_valid_next = 1'b1;
        end else if (out_load) begin
            rd_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the event result while the table read completes
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_result_reg <= ctrl_result;
        end
    end

    // Merge the table channel and advance into the output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_result_reg <= rd_result_reg;
            out_chan_reg   <= rd_result_reg.use_table ? mem_rd_data : rd_result_reg.alt_chan;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_chan_valid    = out_result_reg.chan_valid;
    assign m_radio_chan    = out_chan_reg;
    assign m_link_state    = out_result_reg.link_state;
    assign m_restart_timer = out_result_reg.restart_timer;
    assign m_hop_error     = out_result_reg.hop_error;
    assign m_stats_valid   = out_result_reg.stats_valid;
    assign m_good_total    = out_result_reg.good_total;
    assign m_good_in_sync  = out_result_reg.good_in_sync;
    assign m_lost_waits    = out_result_reg.lost_waits;

endmodule

FILE: dv/hop_receiver_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_receiver_tracker_unit_tb
// Self-checking bench for the receive-side hop tracker.
// ----------------------------------------------------------------------------
// Event words are queued by a sequencer and sent by a clocked driver. Each
// queued word also runs through a tracker predictor in the bench, which keeps
// its own hop table, link mode, sync ring and counters and pushes the expected
// report. A clocked monitor pops one expected report per accepted result word
// and compares every field. The sequencer never selects a table entry that has
// not been loaded: it loads the entry first. Sync channels are rewritten only
// when no report is outstanding.
// ----------------------------------------------------------------------------
module hop_receiver_tracker_unit_tb;
    import hrt_pkg::*;

    localparam int HOP_COUNT = 64;

    typedef struct packed {
        op_t                   op;
        logic [HOP_IDX_W-1:0]  next_hop;
        logic [SLOT_W-1:0]     table_slot;
        logic [CHAN_W-1:0]     table_chan;
    } event_word_t;

    typedef struct packed {
        logic              chan_valid;
        logic [CHAN_W-1:0] radio_chan;
        logic [2:0]        link_state;
        logic              restart_timer;
        logic              hop_error;
        logic              stats_valid;
        logic [CNT_W-1:0]  good_total;
        logic [CNT_W-1:0]  good_in_sync;
        logic [CNT_W-1:0]  lost_waits;
    } report_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_addr        = '0;
    logic [CHAN_W-1:0]    cfg_data        = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_op            = '0;
    logic [HOP_IDX_W-1:0] s_next_hop      = '0;
    logic [SLOT_W-1:0]    s_table_slot    = '0;
    logic [CHAN_W-1:0]    s_table_chan    = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_chan_valid;
    logic [CHAN_W-1:0]    m_radio_chan;
    logic [2:0]           m_link_state;
    logic                 m_restart_timer;
    logic                 m_hop_error;
    logic                 m_stats_valid;
    logic [CNT_W-1:0]     m_good_total;
    logic [CNT_W-1:0]     m_good_in_sync;
    logic [CNT_W-1:0]     m_lost_waits;

    // Pending event words and expected reports, in acceptance order
    event_word_t event_q[$];
    report_t     report_q[$];

    // Predictor state
    logic [CHAN_W-1:0] chan_map [HOP_COUNT];
    bit                chan_loaded [HOP_COUNT];
    logic [5:0]        hop_at      = '0;
    logic [1:0]        ring_at     = '0;
    logic [2:0]        link_now    = MODE_NEED_SYNC;
    logic [CNT_W-1:0]  pkt_total   = '0;
    logic [CNT_W-1:0]  pkt_in_sync = '0;
    logic [CNT_W-1:0]  sync_misses = '0;
    logic [CHAN_W-1:0] sync_chans [3];

    int idle_pct   = 31;
    int queued     = 0;
    int mismatches = 0;

    hop_receiver_tracker_unit #(.HOP_LEN(HOP_COUNT)) dut (.*);

    always #6 aclk = ~aclk;

    // Apply one event word to the tracker state and return its report
    function automatic report_t advance_tracker(input event_word_t ev);
        report_t r;
        r = '0;
        case (ev.op)
            OP_PACKET: begin
                if (ev.next_hop >= HOP_COUNT) begin
                    r.hop_error = 1'b1;
                end else begin
                    if (pkt_total != CNT_MAX) pkt_total = pkt_total + 16'd1;
                    if (link_now == MODE_NEED_SYNC && pkt_in_sync != CNT_MAX)
                        pkt_in_sync = pkt_in_sync + 16'd1;
                    link_now        = MODE_HOPPING;
                    hop_at          = ev.next_hop[5:0];
                    r.chan_valid    = 1'b1;
                    r.radio_chan    = chan_map[hop_at];
                    r.restart_timer = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                r.chan_valid = 1'b1;
                if (link_now < MODE_NEED_SYNC) begin
                    link_now     = link_now + 3'd1;
                    hop_at       = (hop_at == 6'(HOP_COUNT - 1)) ? '0 : hop_at + 6'd1;
                    r.radio_chan = chan_map[hop_at];
                end else begin
                    if (sync_misses != CNT_MAX) sync_misses = sync_misses + 16'd1;
                    ring_at      = (ring_at == SYNC_LAST) ? '0 : ring_at + 2'd1;
                    r.radio_chan = sync_chans[ring_at];
                end
            end
            OP_TICK: begin
                r.stats_valid  = 1'b1;
                r.good_total   = pkt_total;
                r.good_in_sync = pkt_in_sync;
                r.lost_waits   = sync_misses;
                pkt_total      = '0;
                pkt_in_sync    = '0;
                sync_misses    = '0;
            end
            default: begin
                if (ev.table_slot < HOP_COUNT) begin
                    chan_map[ev.table_slot]    = ev.table_chan;
                    chan_loaded[ev.table_slot] = 1'b1;
                end
            end
        endcase
        r.link_state = link_now;
        return r;
    endfunction

    function automatic event_word_t random_word(input op_t op);
        event_word_t ev;
        ev.op         = op;
        ev.next_hop   = HOP_IDX_W'($urandom_range(0, 65535));
        ev.table_slot = SLOT_W'($urandom_range(0, 63));
        ev.table_chan = CHAN_W'($urandom_range(0, 127));
        return ev;
    endfunction

    // Queue a word and its report; load a table entry first if the word would read it unset
    task automatic queue_event(input event_word_t ev);
        event_word_t fill;
        int          idx;
        idx = -1;
        if (ev.op == OP_PACKET && ev.next_hop < HOP_COUNT)
            idx = int'(ev.next_hop);
        else if (ev.op == OP_TIMEOUT && link_now < MODE_NEED_SYNC)
            idx = (hop_at == 6'(HOP_COUNT - 1)) ? 0 : int'(hop_at) + 1;
        if (idx >= 0 && !chan_loaded[idx]) begin
            fill            = random_word(OP_LOAD);
            fill.table_slot = SLOT_W'(idx);
            queue_event(fill);
        end
        while (event_q.size() >= 32) @(posedge aclk);
        event_q.push_back(ev);
        report_q.push_back(advance_tracker(ev));
        queued++;
    endtask

    // arg is the hop index for a packet and the table slot for a load
    task automatic queue_word(input op_t op, input int unsigned arg, input int unsigned chan);
        event_word_t ev;
        ev = random_word(op);
        if (op == OP_PACKET) ev.next_hop = HOP_IDX_W'(arg);
        if (op == OP_LOAD) begin
            ev.table_slot = SLOT_W'(arg);
            ev.table_chan = CHAN_W'(chan);
        end
        queue_event(ev);
    endtask

    task automatic drain_reports();
        while (report_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_sync_chans(input int unsigned a, input int unsigned b,
                                  input int unsigned c);
        logic [CHAN_W-1:0] vals [3];
        vals[0] = CHAN_W'(a);
        vals[1] = CHAN_W'(b);
        vals[2] = CHAN_W'(c);
        for (int i = 0; i < 3; i++) begin
            @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_addr  <= reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cfg_valid <= 1'b0;
            sync_chans[i] = vals[i];
        end
    endtask

    // Mix of packet-then-timeout runs, ticks, loads and noise
    task automatic run_random(input int n);
        int start;
        int pick;
        start = queued;
        while (queued - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_word(OP_PACKET, $urandom_range(0, HOP_COUNT - 1), 0);
                repeat ($urandom_range(0, 8)) queue_word(OP_TIMEOUT, 0, 0);
            end else if (pick < 65) begin
                queue_word(OP_TICK, 0, 0);
            end else if (pick < 80) begin
                queue_word(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 127));
            end else if (pick < 90) begin
                queue_word(OP_PACKET, $urandom_range(0, 65535), 0);
            end else begin
                queue_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
                           $urandom_range(0, 127));
            end
        end
    endtask

    // Send pending words; hold valid and payload until accepted
    always @(posedge aclk) begin
        event_word_t ev;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                ev = event_q.pop_front();
                s_valid      <= 1'b1;
                s_op         <= ev.op;
                s_next_hop   <= ev.next_hop;
                s_table_slot <= ev.table_slot;
                s_table_chan <= ev.table_chan;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random and check each accepted word
    always @(posedge aclk) begin
        report_t want;
        report_t seen;
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
        if (aresetn && m_valid && m_ready) begin
            seen = {m_chan_valid, m_radio_chan, m_link_state, m_restart_timer,
                    m_hop_error, m_stats_valid, m_good_total, m_good_in_sync,
                    m_lost_waits};
            if (report_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: %h", seen);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (seen !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch: chan %b/%0d mode %0d rst %b err %b stats %b %0d/%0d/%0d",
                                 seen.chan_valid, seen.radio_chan, seen.link_state,
                                 seen.restart_timer, seen.hop_error, seen.stats_valid,
                                 seen.good_total, seen.good_in_sync, seen.lost_waits);
                        $display("  expected chan %b/%0d mode %0d rst %b err %b stats %b %0d/%0d/%0d",
                                 want.chan_valid, want.radio_chan, want.link_state,
                                 want.restart_timer, want.hop_error, want.stats_valid,
                                 want.good_total, want.good_in_sync, want.lost_waits);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < HOP_COUNT; i++) begin
            chan_map[i]    = '0;
            chan_loaded[i] = 1'b0;
        end
        for (int i = 0; i < 3; i++) sync_chans[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_sync_chans(0, 127, 85);

        // Directed: reset state, sync ring, hop wrap, range limits, counts
        queue_word(OP_TICK, 0, 0);
        queue_word(OP_TIMEOUT, 0, 0);
        queue_word(OP_LOAD, 0, 0);
        queue_word(OP_LOAD, 63, 127);
        queue_word(OP_LOAD, 1, 85);
        queue_word(OP_PACKET, 65535, 0);
        queue_word(OP_PACKET, HOP_COUNT, 0);
        queue_word(OP_PACKET, HOP_COUNT - 1, 0);
        repeat (6) queue_word(OP_TIMEOUT, 0, 0);
        repeat (3) queue_word(OP_TIMEOUT, 0, 0);
        queue_word(OP_PACKET, 0, 0);
        queue_word(OP_PACKET, 1, 0);
        queue_word(OP_TICK, 0, 0);
        queue_word(OP_TICK, 0, 0);
        queue_word(OP_LOAD, 63, 0);
        queue_word(OP_PACKET, 63, 0);
        drain_reports();

        set_sync_chans(127, 0, 42);
        run_random(475);
        drain_reports();

        // First half of this phase runs without stalls
        set_sync_chans($urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127));
        idle_pct = 0;
        run_random(240);
        idle_pct = 31;
        run_random(235);
        drain_reports();

        set_sync_chans(127, 127, 127);
        run_random(475);
        drain_reports();

        set_sync_chans(0, 0, 0);
        run_random(475);
        drain_reports();

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("hop_receiver_tracker_unit_tb: clean");
        end else begin
            $display("hop_receiver_tracker_unit_tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(40_000_000);
        $display("hop_receiver_tracker_unit_tb: errors");
        $finish;
    end

endmodule
